/* rtl/bsmp_pkg.sv */
`timescale 1ns / 1ps
package bsmp_pkg;
  localparam int MAX_BONES = 256;
  localparam int ELEM_WIDTH = 16;
  localparam int FRAC_BITS = 8;
  localparam int LANE_BITS = 16;
  localparam int STORE_DEPTH = MAX_BONES * 4;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int SUM_W = PROD_W + 2;
  localparam int NUM_LANES = 4;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic [63:0] row_t;

  // Lane result passed to the merge stage.
  typedef struct packed {
    elem_t value;
    logic  sat;
  } lane_res_t;

  // Take column c of a packed row, sign-extended from the element width.
  function automatic elem_t get_elem(input row_t row, input logic [1:0] c);
    logic [LANE_BITS-1:0] lane;
    lane = row[c*LANE_BITS +: LANE_BITS];
    return elem_t'(lane[ELEM_WIDTH-1:0]);
  endfunction

  // Widen an element back into a 16-bit lane.
  function automatic logic [LANE_BITS-1:0] put_elem(input elem_t e);
    return LANE_BITS'(signed'(e));
  endfunction
endpackage

/* rtl/bsmp_if.sv */
`timescale 1ns / 1ps
interface bsmp_in_if;
  logic valid;
  logic ready;
  logic first_bone;
  logic has_parent;
  logic [7:0] parent_index;
  logic [63:0] local_row0, local_row1, local_row2, local_row3;
  logic [63:0] inv_row0, inv_row1, inv_row2, inv_row3;
  modport source (output valid, first_bone, has_parent, parent_index, local_row0,
                  local_row1, local_row2, local_row3, inv_row0, inv_row1, inv_row2,
                  inv_row3, input ready);
  modport sink (input valid, first_bone, has_parent, parent_index, local_row0,
                local_row1, local_row2, local_row3, inv_row0, inv_row1, inv_row2,
                inv_row3, output ready);
endinterface

interface bsmp_out_if;
  logic valid;
  logic ready;
  logic [7:0] bone_number;
  logic [63:0] skin_row0, skin_row1, skin_row2, skin_row3;
  logic bad_parent;
  logic saturated;
  modport source (output valid, bone_number, skin_row0, skin_row1, skin_row2,
                  skin_row3, bad_parent, saturated, input ready);
  modport sink (input valid, bone_number, skin_row0, skin_row1, skin_row2,
                skin_row3, bad_parent, saturated, output ready);
endinterface

/* rtl/bsmp_lane.sv */
`timescale 1ns / 1ps
// One dot-product lane: four products of a row and a column, summed,
// rounded half up and saturated. The product is registered before the sum.
module bsmp_lane (
  input  logic               clk,
  input  bsmp_pkg::elem_t    a [4],
  input  bsmp_pkg::elem_t    b [4],
  output bsmp_pkg::lane_res_t res
);
  logic signed [bsmp_pkg::PROD_W-1:0] prod_r [4];
  logic signed [bsmp_pkg::SUM_W-1:0] sum;
  logic signed [bsmp_pkg::SUM_W-bsmp_pkg::FRAC_BITS-1:0] rnd;
  localparam logic signed [bsmp_pkg::SUM_W-bsmp_pkg::FRAC_BITS-1:0] MAXV =
    (bsmp_pkg::SUM_W-bsmp_pkg::FRAC_BITS)'((1 << (bsmp_pkg::ELEM_WIDTH-1)) - 1);
  localparam logic signed [bsmp_pkg::SUM_W-bsmp_pkg::FRAC_BITS-1:0] MINV = -MAXV - 1;

  // Register the four products.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) prod_r[k] <= a[k] * b[k];
  end

  // Sum, round and saturate.
  always_comb begin
    sum = bsmp_pkg::SUM_W'(prod_r[0]) + bsmp_pkg::SUM_W'(prod_r[1])
        + bsmp_pkg::SUM_W'(prod_r[2]) + bsmp_pkg::SUM_W'(prod_r[3])
        + bsmp_pkg::SUM_W'(1 << (bsmp_pkg::FRAC_BITS-1));
    rnd = sum[bsmp_pkg::SUM_W-1:bsmp_pkg::FRAC_BITS];
    if (rnd > MAXV) begin
      res.value = MAXV[bsmp_pkg::ELEM_WIDTH-1:0];
      res.sat = 1'b1;
    end else if (rnd < MINV) begin
      res.value = MINV[bsmp_pkg::ELEM_WIDTH-1:0];
      res.sat = 1'b1;
    end else begin
      res.value = rnd[bsmp_pkg::ELEM_WIDTH-1:0];
      res.sat = 1'b0;
    end
  end
endmodule

/* rtl/bone_skinning_matrix_palette.sv */
`timescale 1ns / 1ps
// Channel  Dir  Word
// in_      in   bone flags, parent index, local and inverse bind rows
// out_     out  bone number, skinning rows, bad parent, saturated
//
// A bone with a parent passes through these steps from one intake to the next:
// take the word, read the parent rows, form the global product, form the
// skinning product (four rows plus the product register stage each) and hand
// out the result. A root bone skips the parent read and the global product.
// Four lanes of four multipliers, one lane per output column, set the pace.
// rst_n is synchronous and clears control state; the transform memory has
// no reset. A held result word stalls intake until taken.
module bone_skinning_matrix_palette (
  input logic clk,
  input logic rst_n,
  bsmp_in_if.sink in_ch,
  bsmp_out_if.source out_ch
);
  typedef enum logic [2:0] {S_IDLE, S_PRD, S_GMUL, S_SMUL, S_OUT} state_t;
  state_t state_r;
  logic [7:0] cnt_r, idx_r, par_r;
  logic use_par_r, bad_r, sat_r;
  logic [2:0] step_r;
  bsmp_pkg::row_t loc_r [4], inv_r [4], par_m_r [4], glb_r [4], skin_r [4];
  bsmp_pkg::row_t mem [bsmp_pkg::STORE_DEPTH];
  bsmp_pkg::row_t rd_r;
  logic [bsmp_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic wr_en;
  bsmp_pkg::row_t wr_data;
  bsmp_pkg::elem_t la [4][4], lb [4][4];
  bsmp_pkg::lane_res_t lres [4];
  logic [1:0] arow, wrow;
  logic [7:0] idx_n, nxt_n;
  bsmp_pkg::row_t mrow;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.bone_number = idx_r;
  assign out_ch.skin_row0 = skin_r[0];
  assign out_ch.skin_row1 = skin_r[1];
  assign out_ch.skin_row2 = skin_r[2];
  assign out_ch.skin_row3 = skin_r[3];
  assign out_ch.bad_parent = bad_r;
  assign out_ch.saturated = sat_r;

  assign idx_n = in_ch.first_bone ? 8'd0 : cnt_r;
  assign nxt_n = (32'(idx_r) + 1 >= bsmp_pkg::MAX_BONES) ? 8'd0 : idx_r + 8'd1;

  // Row being fed (step counts rows in flight plus one pipeline slot).
  assign arow = step_r[1:0];
  assign wrow = 2'(step_r - 3'd1);

  // Lane operands: row arow of A times each column of B.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        if (state_r == S_GMUL) begin
          la[j][k] = bsmp_pkg::get_elem(loc_r[arow], 2'(k));
          lb[j][k] = bsmp_pkg::get_elem(par_m_r[k], 2'(j));
        end else begin
          la[j][k] = bsmp_pkg::get_elem(inv_r[arow], 2'(k));
          lb[j][k] = bsmp_pkg::get_elem(glb_r[k], 2'(j));
        end
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_lane
    bsmp_lane u_lane (.clk(clk), .a(la[j]), .b(lb[j]), .res(lres[j]));
  end

  // Merge the four lane results into one row.
  always_comb begin
    for (int j = 0; j < 4; j++)
      mrow[j*bsmp_pkg::LANE_BITS +: bsmp_pkg::LANE_BITS] = bsmp_pkg::put_elem(lres[j].value);
  end

  assign rd_addr = bsmp_pkg::ADDR_W'({par_r, step_r[1:0]});
  assign wr_addr = bsmp_pkg::ADDR_W'({idx_r, step_r[1:0]});

  // Transform memory.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  // Global rows are written from glb_r at the start of the skinning pass.
  assign wr_en = (state_r == S_SMUL) && (step_r < 3'd4);
  assign wr_data = glb_r[step_r[1:0]];

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= 8'd0;
      step_r <= 3'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            idx_r <= idx_n;
            par_r <= in_ch.parent_index;
            bad_r <= in_ch.has_parent && (in_ch.parent_index >= idx_n);
            use_par_r <= in_ch.has_parent && (in_ch.parent_index < idx_n);
            sat_r <= 1'b0;
            loc_r[0] <= in_ch.local_row0; loc_r[1] <= in_ch.local_row1;
            loc_r[2] <= in_ch.local_row2; loc_r[3] <= in_ch.local_row3;
            inv_r[0] <= in_ch.inv_row0; inv_r[1] <= in_ch.inv_row1;
            inv_r[2] <= in_ch.inv_row2; inv_r[3] <= in_ch.inv_row3;
            step_r <= 3'd0;
            state_r <= S_PRD;
          end
        end
        S_PRD: begin
          if (!use_par_r) begin
            glb_r <= loc_r;
            step_r <= 3'd0;
            state_r <= S_SMUL;
          end else begin
            // Read data lands in the cycle after its address.
            if (step_r != 3'd0) par_m_r[2'(step_r - 3'd1)] <= rd_r;
            if (step_r == 3'd4) begin
              step_r <= 3'd0;
              state_r <= S_GMUL;
            end else step_r <= step_r + 3'd1;
          end
        end
        S_GMUL: begin
          if (step_r != 3'd0) begin
            glb_r[wrow] <= mrow;
            sat_r <= sat_r | lres[0].sat | lres[1].sat | lres[2].sat | lres[3].sat;
          end
          if (step_r == 3'd4) begin
            step_r <= 3'd0;
            state_r <= S_SMUL;
          end else step_r <= step_r + 3'd1;
        end
        S_SMUL: begin
          if (step_r != 3'd0) begin
            skin_r[wrow] <= mrow;
            sat_r <= sat_r | lres[0].sat | lres[1].sat | lres[2].sat | lres[3].sat;
          end
          if (step_r == 3'd4) state_r <= S_OUT;
          else step_r <= step_r + 3'd1;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            cnt_r <= nxt_n;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A stalled result word holds, intake stays closed while it waits, and a
  // bad parent is never used.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.skin_row0))
    else $error("result word changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("intake open while result pending");
  a_bad_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(bad_r && use_par_r))
    else $error("bad parent used as parent");
endmodule

/* tb/bsmp_tb_if.sv */
`timescale 1ns / 1ps
// Testbench-side channel view: a single bone word or skinning word, used by the predictor.
package bsmp_tb_pkg;
  typedef struct {
    logic           first_bone;
    logic           has_parent;
    logic [7:0]     parent_index;
    bsmp_pkg::row_t loc[4];
    bsmp_pkg::row_t inv[4];
  } bone_word_t;

  typedef struct {
    logic [7:0]     bone_number;
    bsmp_pkg::row_t skin[4];
    logic           bad_parent;
    logic           saturated;
  } skin_word_t;
endpackage

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  typedef longint mat_t[4][4];

  logic clk;
  logic rst_n;
  bsmp_in_if  in_ch();
  bsmp_out_if out_ch();

  bone_skinning_matrix_palette u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  // Clock: 10 ns period.
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Predictor state: the global transform memory and the next bone number.
  bsmp_pkg::row_t          global_rows[bsmp_pkg::STORE_DEPTH];
  bit                      global_written[bsmp_pkg::MAX_BONES];
  int                      next_bone;
  bsmp_tb_pkg::skin_word_t expected_skins[$];
  int                      error_count;
  int                      bones_sent;
  int                      skins_seen;
  int                      sat_seen;
  int                      bad_seen;
  int                      idle_pct;
  int                      stall_pct;
  int                      quiet_cycles;

  // Sign-extend element lanes of four rows into a matrix.
  function automatic void unpack_matrix(input bsmp_pkg::row_t rows[4], output mat_t m);
    logic [bsmp_pkg::ELEM_WIDTH-1:0] v;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        v = rows[r][c*bsmp_pkg::LANE_BITS +: bsmp_pkg::ELEM_WIDTH];
        m[r][c] = longint'(signed'(v));
      end
    end
  endfunction

  function automatic void pack_matrix(input mat_t m, output bsmp_pkg::row_t rows[4]);
    logic [15:0] lane;
    for (int r = 0; r < 4; r++) begin
      rows[r] = '0;
      for (int c = 0; c < 4; c++) begin
        lane = m[r][c][15:0];
        rows[r][c*bsmp_pkg::LANE_BITS +: bsmp_pkg::LANE_BITS] = lane;
      end
    end
  endfunction

  // Row-vector product with round half up and saturation.
  function automatic void fixed_matmul(input mat_t a, input mat_t b, output mat_t o,
                                       inout logic sat);
    longint acc;
    longint maxv;
    longint minv;
    maxv = (longint'(1) <<< (bsmp_pkg::ELEM_WIDTH - 1)) - 1;
    minv = -maxv - 1;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += a[i][k] * b[k][j];
        acc = (acc + (longint'(1) <<< (bsmp_pkg::FRAC_BITS - 1))) >>> bsmp_pkg::FRAC_BITS;
        if (acc > maxv) begin
          sat = 1'b1;
          acc = maxv;
        end else if (acc < minv) begin
          sat = 1'b1;
          acc = minv;
        end
        o[i][j] = acc;
      end
    end
  endfunction

  // Work out the skinning word for one accepted bone and update the memory.
  function automatic bsmp_tb_pkg::skin_word_t predict_skin(input bsmp_tb_pkg::bone_word_t b);
    bsmp_tb_pkg::skin_word_t s;
    mat_t loc, inv, par, glob, skin;
    bsmp_pkg::row_t prow[4];
    bsmp_pkg::row_t grow[4];
    int idx;
    logic bad;
    logic sat;
    idx = b.first_bone ? 0 : next_bone;
    if (idx >= bsmp_pkg::MAX_BONES || idx > 255) idx = 0;
    bad = b.has_parent && (b.parent_index >= idx);
    sat = 1'b0;
    unpack_matrix(b.loc, loc);
    unpack_matrix(b.inv, inv);
    if (b.has_parent && !bad) begin
      for (int r = 0; r < 4; r++)
        prow[r] = global_rows[(b.parent_index * 4 + r) % bsmp_pkg::STORE_DEPTH];
      unpack_matrix(prow, par);
      fixed_matmul(loc, par, glob, sat);
    end else begin
      glob = loc;
    end
    pack_matrix(glob, grow);
    unpack_matrix(grow, glob);
    for (int r = 0; r < 4; r++) global_rows[(idx * 4 + r) % bsmp_pkg::STORE_DEPTH] = grow[r];
    global_written[idx] = 1'b1;
    fixed_matmul(inv, glob, skin, sat);
    pack_matrix(skin, s.skin);
    s.bone_number = idx[7:0];
    s.bad_parent = bad;
    s.saturated = sat;
    next_bone = (idx + 1 >= bsmp_pkg::MAX_BONES || idx + 1 > 255) ? 0 : idx + 1;
    return s;
  endfunction

  // Drive one bone word and wait until it is taken. The word stays on the bus
  // until the next falling edge, where the next call replaces or drops it.
  task automatic send_bone(input bsmp_tb_pkg::bone_word_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.first_bone   <= b.first_bone;
    in_ch.has_parent   <= b.has_parent;
    in_ch.parent_index <= b.parent_index;
    in_ch.local_row0 <= b.loc[0];
    in_ch.local_row1 <= b.loc[1];
    in_ch.local_row2 <= b.loc[2];
    in_ch.local_row3 <= b.loc[3];
    in_ch.inv_row0   <= b.inv[0];
    in_ch.inv_row1   <= b.inv[1];
    in_ch.inv_row2   <= b.inv[2];
    in_ch.inv_row3   <= b.inv[3];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_skins.push_back(predict_skin(b));
    bones_sent++;
    @(negedge clk);
  endtask

  // Random element within a modest range so products rarely saturate.
  function automatic logic [15:0] tame_elem();
    int v;
    v = $urandom_range(767) - 384;
    return v[15:0];
  endfunction

  function automatic bsmp_pkg::row_t random_row(input int mode);
    bsmp_pkg::row_t r;
    for (int c = 0; c < 4; c++) begin
      if (mode == 0) r[c*16 +: 16] = tame_elem();
      else r[c*16 +: 16] = 16'($urandom());
    end
    return r;
  endfunction

  function automatic void fill_identity(output bsmp_pkg::row_t rows[4]);
    for (int r = 0; r < 4; r++) begin
      rows[r] = '0;
      rows[r][r*16 +: 16] = 16'h0100;
    end
  endfunction

  // Build a bone whose parent, if any, has a lower number, except for an occasional bad parent at or above it.
  function automatic bsmp_tb_pkg::bone_word_t random_bone(input logic first, input int mode);
    bsmp_tb_pkg::bone_word_t b;
    int idx;
    idx = first ? 0 : next_bone;
    b.first_bone = first;
    b.has_parent = (idx > 0) && ($urandom_range(99) < 80);
    b.parent_index = b.has_parent ? 8'($urandom_range(idx - 1)) : 8'($urandom());
    // A bad parent is only safe when it points at or above the current number.
    if (!b.has_parent && $urandom_range(99) < 5) begin
      b.has_parent = 1'b1;
      b.parent_index = 8'($urandom_range(255, idx));
    end
    for (int r = 0; r < 4; r++) begin
      b.loc[r] = random_row(mode);
      b.inv[r] = random_row(mode);
    end
    return b;
  endfunction

  // Check each skinning word against the oldest expectation.
  always @(posedge clk) begin
    bsmp_tb_pkg::skin_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      skins_seen++;
      if (expected_skins.size() == 0) begin
        $display("%0t: unexpected skinning word for bone %0d", $time, out_ch.bone_number);
        error_count++;
      end else begin
        want = expected_skins.pop_front();
        if (want.saturated) sat_seen++;
        if (want.bad_parent) bad_seen++;
        if (out_ch.bone_number !== want.bone_number) begin
          $display("%0t: bone_number expected %0d actual %0d", $time, want.bone_number,
                   out_ch.bone_number);
          error_count++;
        end
        if (out_ch.skin_row0 !== want.skin[0] || out_ch.skin_row1 !== want.skin[1] ||
            out_ch.skin_row2 !== want.skin[2] || out_ch.skin_row3 !== want.skin[3]) begin
          $display("%0t: skin rows expected %h %h %h %h actual %h %h %h %h", $time,
                   want.skin[0], want.skin[1], want.skin[2], want.skin[3], out_ch.skin_row0,
                   out_ch.skin_row1, out_ch.skin_row2, out_ch.skin_row3);
          error_count++;
        end
        if (out_ch.bad_parent !== want.bad_parent) begin
          $display("%0t: bad_parent expected %b actual %b", $time, want.bad_parent,
                   out_ch.bad_parent);
          error_count++;
        end
        if (out_ch.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   out_ch.saturated);
          error_count++;
        end
      end
    end
  end

  // Result side stalls at random.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 5000) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_skins.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drop the input and wait until every expected result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_skins.size() != 0) @(negedge clk);
  endtask

  // Extremes, identity chains, bad parents, half-LSB rounding and a numbering restart.
  task automatic test_directed();
    bsmp_tb_pkg::bone_word_t b;
    fill_identity(b.loc);
    fill_identity(b.inv);
    b.first_bone = 1'b1; b.has_parent = 1'b0; b.parent_index = 8'd0;
    send_bone(b);
    b.first_bone = 1'b0; b.has_parent = 1'b1; b.parent_index = 8'd0;
    send_bone(b);
    // Parent equal to own number, then far above it.
    b.parent_index = 8'd2;
    send_bone(b);
    b.parent_index = 8'd255;
    send_bone(b);
    // All-ones and all-zeros rows, valid parent.
    for (int r = 0; r < 4; r++) begin
      b.loc[r] = '1;
      b.inv[r] = '0;
    end
    b.parent_index = 8'd1;
    send_bone(b);
    // Largest magnitudes to force saturation both ways.
    for (int r = 0; r < 4; r++) begin
      b.loc[r] = {4{16'h7fff}};
      b.inv[r] = {4{16'h8000}};
    end
    b.has_parent = 1'b0;
    send_bone(b);
    b.has_parent = 1'b1; b.parent_index = 8'd5;
    send_bone(b);
    for (int r = 0; r < 4; r++) b.inv[r] = {4{16'h7fff}};
    send_bone(b);
    // Half-LSB rounding: 0.5 LSB products.
    fill_identity(b.inv);
    for (int r = 0; r < 4; r++) b.loc[r] = {16'h0001, 16'hffff, 16'h0080, 16'hff80};
    b.has_parent = 1'b0;
    send_bone(b);
    b.has_parent = 1'b1; b.parent_index = 8'd8;
    send_bone(b);
    // Restart numbering mid-skeleton.
    b.first_bone = 1'b1; b.has_parent = 1'b1; b.parent_index = 8'd0;
    send_bone(b);
    wait_drained();
  endtask

  // Long skeleton that runs the bone number through its wrap.
  task automatic test_numbering_wrap();
    bsmp_tb_pkg::bone_word_t b;
    b = random_bone(1'b1, 0);
    send_bone(b);
    for (int i = 0; i < 300; i++) begin
      b = random_bone(1'b0, $urandom_range(9) == 0);
      // After the wrap, only parents written since the wrap are safe.
      if (b.has_parent && b.parent_index < next_bone && !global_written[b.parent_index])
        b.has_parent = 1'b0;
      send_bone(b);
    end
  endtask

  // Many short skeletons with random contents.
  task automatic test_random_skeletons(input int count);
    bsmp_tb_pkg::bone_word_t b;
    int left;
    left = count;
    while (left > 0) begin
      for (int i = 0; i < bsmp_pkg::MAX_BONES; i++) global_written[i] = 1'b0;
      b = random_bone(1'b1, $urandom_range(3) == 0);
      send_bone(b);
      left--;
      for (int n = $urandom_range(30); n > 0 && left > 0; n--) begin
        b = random_bone(1'b0, $urandom_range(3) == 0);
        send_bone(b);
        left--;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_bone = 1'b0;
    in_ch.has_parent = 1'b0;
    in_ch.parent_index = '0;
    in_ch.local_row0 = '0; in_ch.local_row1 = '0;
    in_ch.local_row2 = '0; in_ch.local_row3 = '0;
    in_ch.inv_row0 = '0; in_ch.inv_row1 = '0;
    in_ch.inv_row2 = '0; in_ch.inv_row3 = '0;
    out_ch.ready = 1'b0;
    error_count = 0; bones_sent = 0; skins_seen = 0; sat_seen = 0; bad_seen = 0;
    quiet_cycles = 0; next_bone = 0;
    idle_pct = 22; stall_pct = 22;
    for (int i = 0; i < bsmp_pkg::STORE_DEPTH; i++) global_rows[i] = '0;
    for (int i = 0; i < bsmp_pkg::MAX_BONES; i++) global_written[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_numbering_wrap();
    wait_drained();
    // A stretch with no idling on either side.
    idle_pct = 0; stall_pct = 0;
    test_random_skeletons(300);
    idle_pct = 22; stall_pct = 22;
    test_random_skeletons(630);

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d bones, checked %0d skinning words (%0d saturated, %0d bad parent).",
             bones_sent, skins_seen, sat_seen, bad_seen);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
